@@ hw/rtl/qsu_pkg.sv @@
// package: codes, types and utf-8 encoder for the quoted string unescaper
`timescale 1ns / 1ps

package qsu_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = 3;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_IN   = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  localparam logic [1:0] K_DATA   = 2'd0;
  localparam logic [1:0] K_CLOSED = 2'd1;
  localparam logic [1:0] K_SYNTAX = 2'd2;
  localparam logic [1:0] K_UNTERM = 2'd3;

  localparam logic [20:0] CH_QUOTE  = 21'h22;
  localparam logic [20:0] CH_BSLASH = 21'h5c;
  localparam logic [20:0] CH_LF     = 21'h0a;
  localparam logic [20:0] CH_N      = 21'h6e;
  localparam logic [20:0] CH_T      = 21'h74;
  localparam logic [20:0] CH_U      = 21'h75;
  localparam logic [20:0] CH_0      = 21'h30;
  localparam logic [20:0] CH_9      = 21'h39;
  localparam logic [20:0] CH_A      = 21'h61;
  localparam logic [20:0] CH_F      = 21'h66;

  localparam logic [7:0] BYTE_LF     = 8'h0a;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_BSLASH = 8'h5c;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } res_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] hex_value;
    logic [2:0]  hex_count;
  } st_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
    st_t                st;
  } dec_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.len  = 3'd1;
      u.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      u.len  = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.len  = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.len  = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

@@ hw/rtl/qsu_decode.sv @@
// decoder: next state and result list for one input character
`timescale 1ns / 1ps

module qsu_decode import qsu_pkg::*; (
  input  logic [20:0] ch,
  input  logic        buffer_end,
  input  st_t         st,
  output dec_t        dec
);

  always_comb begin
    st_t              s;
    logic             single_en;
    res_t             single;
    logic             pre_en;
    logic             enc_en;
    logic [20:0]      enc_cp;
    utf8_t            u;
    logic [CNT_W-1:0] n;
    logic [3:0]       digit;
    logic             digit_ok;
    logic [2:0]       cnt_inc;
    res_t [MAX_RES-1:0] r;

    s         = st;
    single_en = 1'b0;
    single    = '{data: 8'h00, kind: K_DATA};
    pre_en    = 1'b0;
    enc_en    = 1'b0;
    enc_cp    = ch;
    digit     = 4'd0;
    digit_ok  = 1'b0;
    cnt_inc   = 3'(st.hex_count + 3'd1);

    unique case (st.phase)
      PH_WAIT: begin
        if (ch == CH_QUOTE) begin
          s.phase = PH_IN;
        end else begin
          single_en = 1'b1;
          single    = '{data: 8'h00, kind: K_SYNTAX};
        end
      end
      PH_IN: begin
        if (ch == CH_BSLASH) begin
          s.phase = PH_ESC;
        end else if (ch == CH_QUOTE) begin
          single_en = 1'b1;
          single    = '{data: 8'h00, kind: K_CLOSED};
          s.phase   = PH_WAIT;
        end else begin
          enc_en = 1'b1;
        end
      end
      PH_ESC: begin
        s.phase = PH_IN;
        if (ch == CH_N || ch == CH_LF) begin
          single_en = 1'b1;
          single    = '{data: BYTE_LF, kind: K_DATA};
        end else if (ch == CH_T) begin
          single_en = 1'b1;
          single    = '{data: BYTE_TAB, kind: K_DATA};
        end else if (ch == CH_BSLASH) begin
          single_en = 1'b1;
          single    = '{data: BYTE_BSLASH, kind: K_DATA};
        end else if (ch == CH_U) begin
          s.hex_value = 16'h0000;
          s.hex_count = 3'd0;
          s.phase     = PH_HEX;
        end else begin
          pre_en = 1'b1;
          enc_en = 1'b1;
        end
      end
      PH_HEX: begin
        if (ch >= CH_0 && ch <= CH_9) begin
          digit_ok = 1'b1;
          digit    = ch[3:0];
        end else if (ch >= CH_A && ch <= CH_F) begin
          digit_ok = 1'b1;
          digit    = 4'(ch[3:0] + 4'd9);
        end
        if (!digit_ok) begin
          single_en   = 1'b1;
          single      = '{data: 8'h00, kind: K_SYNTAX};
          s.phase     = PH_WAIT;
          s.hex_value = 16'h0000;
          s.hex_count = 3'd0;
        end else if (cnt_inc >= 3'd4) begin
          enc_en      = 1'b1;
          enc_cp      = {5'd0, st.hex_value[11:0], digit};
          s.hex_value = 16'h0000;
          s.hex_count = 3'd0;
          s.phase     = PH_IN;
        end else begin
          s.hex_value = {st.hex_value[11:0], digit};
          s.hex_count = cnt_inc;
        end
      end
      default: begin
        s = st;
      end
    endcase

    u = utf8_enc(enc_cp);

    // assemble the result list, capped at the buffer depth
    r = '0;
    n = '0;
    if (single_en) begin
      r[0] = single;
      n    = CNT_W'(1);
    end
    if (pre_en) begin
      r[0] = '{data: BYTE_BSLASH, kind: K_DATA};
      n    = CNT_W'(1);
    end
    if (enc_en) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < u.len) begin
          r[CNT_W'(n + CNT_W'(i))] = '{data: u.b[i], kind: K_DATA};
        end
      end
      n = CNT_W'(n + u.len);
    end

    if (buffer_end && s.phase != PH_WAIT) begin
      if (n < CNT_W'(MAX_RES)) begin
        r[n] = '{data: 8'h00, kind: K_UNTERM};
        n    = CNT_W'(n + CNT_W'(1));
      end
      s.phase     = PH_WAIT;
      s.hex_value = 16'h0000;
      s.hex_count = 3'd0;
    end

    dec.res = r;
    dec.cnt = n;
    dec.st  = s;
  end

endmodule

@@ hw/rtl/quoted_string_unescape_utf8_unit.sv @@
// top level: quoted string unescaper with utf-8 result buffer
`timescale 1ns / 1ps

// Takes one code point per item and decodes a double-quoted string with
// \n, \t, \\, backslash-newline and \uXXXX escapes into UTF-8 bytes. Each
// item gives zero to five results (data byte, string closed, syntax error or
// unterminated string); out_final_res marks the last result of an item. An
// item is decoded in the cycle it is accepted and its results go into a
// small buffer that drains one result per cycle while out_stall is low. A
// new item is accepted while the last result of the previous one is taken,
// so single-byte characters run at one item per cycle while out_stall is
// low; an item with more results holds the input until its last is taken.
module quoted_string_unescape_utf8_unit import qsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [20:0] in_ch,
  input  logic        in_buffer_end,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_final_res,
  output logic        out_valid,
  input  logic        out_stall
);

  st_t                st_r;
  dec_t               dec;
  res_t [MAX_RES-1:0] res_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   idx_nxt;
  logic               last_idx;
  logic               out_take;
  logic               in_take;

  qsu_decode u_decode (
    .ch         (in_ch),
    .buffer_end (in_buffer_end),
    .st         (st_r),
    .dec        (dec)
  );

  assign out_valid     = (cnt_r != '0);
  assign last_idx      = (idx_r == CNT_W'(cnt_r - CNT_W'(1)));
  assign out_take      = out_valid && !out_stall;
  assign in_stall      = out_valid && !(out_take && last_idx);
  assign in_take       = in_valid && !in_stall;
  assign idx_nxt       = CNT_W'(idx_r + CNT_W'(1));

  assign out_byte      = res_r[idx_r].data;
  assign out_kind      = res_r[idx_r].kind;
  assign out_final_res = last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{phase: PH_WAIT, hex_value: 16'h0000, hex_count: 3'd0};
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (in_take) begin
        st_r  <= dec.st;
        cnt_r <= dec.cnt;
        idx_r <= '0;
      end else if (out_take) begin
        if (last_idx) begin
          cnt_r <= '0;
          idx_r <= '0;
        end else begin
          idx_r <= idx_nxt;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= dec.res;
    end
  end

endmodule

@@ sim/unescape_checker.sv @@
// checker for the quoted string unescaper: predicts the results of each item and compares them
`timescale 1ns / 1ps

module unescape_checker import qsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [20:0] in_ch,
  input  logic        in_buffer_end,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  out_kind,
  input  logic        out_final_res,
  input  logic        out_valid,
  input  logic        out_stall,
  output int          mismatches,
  output int          results_due
);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  decoded_t    due_q[$];
  decoded_t    char_res[$];
  decoded_t    want;
  logic [1:0]  phase;
  logic [15:0] hex_acc;
  logic [2:0]  hex_seen;
  int          res_idx;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // the block keeps at most MAX_RES results per item, later ones are lost
  function automatic void emit(input logic [1:0] kind, input logic [7:0] data);
    decoded_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    if (char_res.size() < MAX_RES)
      char_res.push_back(r);
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(K_DATA, {1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      emit(K_DATA, {3'b110, cp[10:6]});
      emit(K_DATA, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit(K_DATA, {4'b1110, cp[15:12]});
      emit(K_DATA, {2'b10, cp[11:6]});
      emit(K_DATA, {2'b10, cp[5:0]});
    end else begin
      emit(K_DATA, {5'b11110, cp[20:18]});
      emit(K_DATA, {2'b10, cp[17:12]});
      emit(K_DATA, {2'b10, cp[11:6]});
      emit(K_DATA, {2'b10, cp[5:0]});
    end
  endfunction

  task automatic decode_char(input logic [20:0] c, input logic buf_end);
    logic [20:0] off;
    logic        is_hex;
    decoded_t    r;
    char_res.delete();
    case (phase)
      PH_WAIT: begin
        if (c == CH_QUOTE)
          phase = PH_IN;
        else
          emit(K_SYNTAX, 8'h00);
      end
      PH_IN: begin
        if (c == CH_BSLASH) begin
          phase = PH_ESC;
        end else if (c == CH_QUOTE) begin
          emit(K_CLOSED, 8'h00);
          phase = PH_WAIT;
        end else begin
          emit_utf8(c);
        end
      end
      PH_ESC: begin
        phase = PH_IN;
        if (c == CH_N || c == CH_LF) begin
          emit(K_DATA, BYTE_LF);
        end else if (c == CH_T) begin
          emit(K_DATA, BYTE_TAB);
        end else if (c == CH_BSLASH) begin
          emit(K_DATA, BYTE_BSLASH);
        end else if (c == CH_U) begin
          hex_acc  = '0;
          hex_seen = '0;
          phase    = PH_HEX;
        end else begin
          // unknown escape keeps the backslash
          emit(K_DATA, BYTE_BSLASH);
          emit_utf8(c);
        end
      end
      default: begin
        is_hex = 1'b1;
        off    = '0;
        if (c >= CH_0 && c <= CH_9)
          off = c - CH_0;
        else if (c >= CH_A && c <= CH_F)
          off = c - CH_A + 21'd10;
        else
          is_hex = 1'b0;
        if (!is_hex) begin
          emit(K_SYNTAX, 8'h00);
          phase    = PH_WAIT;
          hex_acc  = '0;
          hex_seen = '0;
        end else begin
          hex_acc  = {hex_acc[11:0], off[3:0]};
          hex_seen = hex_seen + 3'd1;
          if (hex_seen >= 3'd4) begin
            emit_utf8({5'd0, hex_acc});
            hex_acc  = '0;
            hex_seen = '0;
            phase    = PH_IN;
          end
        end
      end
    endcase
    if (buf_end && phase != PH_WAIT) begin
      emit(K_UNTERM, 8'h00);
      phase    = PH_WAIT;
      hex_acc  = '0;
      hex_seen = '0;
    end
    foreach (char_res[i]) begin
      r      = char_res[i];
      r.last = (i == char_res.size() - 1);
      due_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase    = PH_WAIT;
      hex_acc  = '0;
      hex_seen = '0;
      res_idx  = 0;
      due_q.delete();
    end else begin
      if (in_valid && !in_stall)
        decode_char(in_ch, in_buffer_end);
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result %0d not expected: byte 0x%02h kind %0d final %0b",
                                    res_idx, out_byte, out_kind, out_final_res));
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("result %0d byte 0x%02h, expected 0x%02h",
                                      res_idx, out_byte, want.data));
          if (out_kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                      res_idx, out_kind, want.kind));
          if (out_final_res !== want.last)
            report_mismatch($sformatf("result %0d final flag %0b, expected %0b",
                                      res_idx, out_final_res, want.last));
        end
        res_idx++;
      end
    end
    results_due = due_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// testbench top: drives character items and result stalls into the unescaper and gives the verdict
`timescale 1ns / 1ps

module tb_top;
  import qsu_pkg::*;

  localparam int          CHAR_ITEMS  = 430;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          SETTLE      = 20;
  localparam logic [20:0] CH_UPPER_A  = 21'h41;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [20:0] in_ch = '0;
  logic        in_buffer_end = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_final_res;
  logic        out_valid;
  logic        out_stall = 1'b0;

  int          mismatches;
  int          results_due;
  int          sent;
  int          quiet;
  int          src_burst;
  int          sink_burst;
  int          sink_wait;
  int          sink_draw;
  logic [20:0] text[$];
  logic        end_flag;

  quoted_string_unescape_utf8_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .in_buffer_end (in_buffer_end),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_final_res (out_final_res),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  unescape_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .in_buffer_end (in_buffer_end),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_final_res (out_final_res),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mismatches    (mismatches),
    .results_due   (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // wait cycles per item, with stretches of back-to-back items
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [20:0] rand_char();
    logic [20:0] c;
    logic [31:0] raw;
    do begin
      raw = $urandom();
      case ($urandom_range(0, 7))
        0, 1, 2: c = 21'($urandom_range(32, 126));
        3:       c = 21'($urandom_range(0, 31));
        4:       c = 21'($urandom_range(21'h80, 21'h7ff));
        5:       c = 21'($urandom_range(21'h800, 21'hffff));
        6:       c = 21'($urandom_range(21'h10000, 21'h10ffff));
        default: c = raw[20:0];
      endcase
    end while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [20:0] hex_char(input int d);
    return (d < 10) ? 21'(CH_0 + d) : 21'(CH_A + (d - 10));
  endfunction

  function automatic logic [20:0] bad_hex_char();
    logic [20:0] c;
    case ($urandom_range(0, 5))
      0:       c = CH_0 - 21'd1;
      1:       c = CH_9 + 21'd1;
      2:       c = CH_A - 21'd1;
      3:       c = CH_F + 21'd1;
      4:       c = CH_UPPER_A;
      default: c = rand_char();
    endcase
    return c;
  endfunction

  task automatic add_piece();
    int d;
    case ($urandom_range(0, 9))
      0: begin
        text.push_back(CH_BSLASH);
        case ($urandom_range(0, 3))
          0:       text.push_back(CH_N);
          1:       text.push_back(CH_T);
          2:       text.push_back(CH_BSLASH);
          default: text.push_back(CH_LF);
        endcase
      end
      1: begin
        text.push_back(CH_BSLASH);
        text.push_back(CH_U);
        repeat (4) begin
          d = $urandom_range(0, 15);
          text.push_back(hex_char(d));
        end
      end
      2: begin
        text.push_back(CH_BSLASH);
        text.push_back(($urandom_range(0, 3) == 0) ? CH_QUOTE : rand_char());
      end
      default: text.push_back(rand_char());
    endcase
  endtask

  task automatic build_string();
    int mode;
    int cut;
    text.delete();
    text.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 8)) add_piece();
    mode     = $urandom_range(0, 9);
    end_flag = 1'($urandom_range(0, 1));
    if (mode == 0) begin
      // buffer runs out inside the string
      cut = $urandom_range(1, text.size());
      while (text.size() > cut) text.delete(text.size() - 1);
      end_flag = 1'b1;
    end else if (mode == 1) begin
      text.push_back(CH_BSLASH);
      text.push_back(CH_U);
      repeat ($urandom_range(0, 3)) text.push_back(hex_char($urandom_range(0, 15)));
      text.push_back(bad_hex_char());
    end else begin
      text.push_back(CH_QUOTE);
    end
  endtask

  task automatic send(input logic [20:0] c, input logic buf_end);
    int gap;
    gap = draw_wait(src_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch         <= c;
    in_buffer_end <= buf_end;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_wait <= 0;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      out_stall <= (sink_wait > 1);
    end else if (out_valid && !out_stall) begin
      sink_draw = draw_wait(sink_burst);
      sink_wait <= sink_draw;
      out_stall <= (sink_draw > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("quoted_string_unescape_utf8_unit regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // non-quote while waiting, buffer end there has no effect
    send(CH_A, 1'b1);
    send(CH_QUOTE, 1'b0);
    send(21'h000000, 1'b0);
    send(21'h00d800, 1'b0);
    send(21'h10ffff, 1'b0);
    send(21'h1fffff, 1'b0);
    send(CH_BSLASH, 1'b0); send(CH_N, 1'b0);
    send(CH_BSLASH, 1'b0); send(CH_LF, 1'b0);
    send(CH_BSLASH, 1'b0); send(CH_T, 1'b0);
    send(CH_BSLASH, 1'b0); send(CH_BSLASH, 1'b0);
    send(CH_BSLASH, 1'b0); send(CH_U, 1'b0);
    send(CH_0, 1'b0); send(CH_9, 1'b0); send(CH_A, 1'b0); send(CH_F, 1'b0);
    // escaped quote does not close
    send(CH_BSLASH, 1'b0); send(CH_QUOTE, 1'b0);
    send(CH_QUOTE, 1'b0);
    send(CH_QUOTE, 1'b1);
    // unknown wide escape at buffer end fills all result slots
    send(CH_QUOTE, 1'b0); send(CH_BSLASH, 1'b0); send(21'h10ffff, 1'b1);
    // bad hex digit wins over buffer end
    send(CH_QUOTE, 1'b0); send(CH_BSLASH, 1'b0); send(CH_U, 1'b0);
    send(CH_9 + 21'd1, 1'b1);
    drain();

    while (sent < CHAR_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0:       send(CH_QUOTE, 1'($urandom_range(0, 1)));
            1:       send(CH_BSLASH, 1'($urandom_range(0, 1)));
            default: send(rand_char(), 1'($urandom_range(0, 1)));
          endcase
        end
      end else begin
        build_string();
        foreach (text[i]) send(text[i], end_flag && (i == text.size() - 1));
        if ($urandom_range(0, 24) == 0)
          drain();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("quoted_string_unescape_utf8_unit regression: pass");
    else
      $display("quoted_string_unescape_utf8_unit regression: fail");
    $finish;
  end

endmodule
